// ----- rtl/lstx_pkg.sv -----
// Package with shared types, constants and the helper functions of the scan converter.
`timescale 1ns / 1ps
package lstx_pkg;

  localparam int MAX_POINTS = 361;
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;
  localparam logic [9:0] COUNT_MAX = 10'd1000;
  localparam logic [9:0] COUNT_FALLBACK = 10'd360;
  localparam logic [16:0] VALUE_CAP = 17'd65535;

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_OK = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] MATCH_FAIL = 3'd7;

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_COUNT,
    PH_DIST,
    PH_DONE
  } phase_t;

  // One job handed from the parser to the point engine.
  typedef struct packed {
    logic        is_status;
    logic        status_ok;
    logic        emit;
    logic [9:0]  index;
    logic [9:0]  total;
    logic [16:0] radius;
  } job_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  point_index;
    logic [16:0] x_mm;
    logic [16:0] y_mm;
    logic        last;
  } result_t;

  typedef enum logic [3:0] {
    EN_IDLE,
    EN_DIV,
    EN_SQ,
    EN_POLY,
    EN_FIN,
    EN_SCALE,
    EN_OUT
  } eng_state_t;

  function automatic logic [30:0] sin_coef(input logic [2:0] k);
    case (k)
      3'd0: sin_coef = 31'd1686629713;
      3'd1: sin_coef = 31'd693598669;
      3'd2: sin_coef = 31'd85569306;
      3'd3: sin_coef = 31'd5026995;
      3'd4: sin_coef = 31'd172272;
      3'd5: sin_coef = 31'd3864;
      3'd6: sin_coef = 31'd61;
      default: sin_coef = 31'd0;
    endcase
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    to_upper = (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] marker_char(input logic [2:0] i);
    case (i)
      3'd0: marker_char = "D";
      3'd1: marker_char = "I";
      3'd2: marker_char = "S";
      3'd3: marker_char = "T";
      3'd4: marker_char = "1";
      default: marker_char = 8'h00;
    endcase
  endfunction

endpackage

// ----- rtl/lstx_fifo.sv -----
// Short job queue between the byte parser and the point engine.
`timescale 1ns / 1ps
module lstx_fifo
  import lstx_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);

  job_t slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic push;
  logic pop;

  assign in_ready = (fill != 3'd4);
  assign out_valid = (fill != 3'd0);
  assign out_job = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {2'b0, push} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_job;
  end

endmodule

// ----- rtl/lstx_parser.sv -----
// Byte parser that tokenizes the reply and queues point and status jobs.
`timescale 1ns / 1ps
module lstx_parser
  import lstx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] rx_byte,
  output logic       job_valid,
  input  logic       job_ready,
  output job_t       job
);

  logic        in_frame;
  phase_t      parse_phase;
  logic [2:0]  marker_match;
  logic [7:0]  token_length;
  logic [16:0] hex_value;
  logic [16:0] decimal_value;
  logic [2:0]  token_flags;
  logic [9:0]  point_total;
  logic [9:0]  point_counter;
  logic        pend_status;

  logic [7:0]  up;
  logic        is_sep;
  logic        is_etx;
  logic        is_dig;
  logic        is_hex;
  logic [3:0]  hd;
  logic [20:0] dec_mul;
  logic [20:0] hex_mul;
  logic        tok_end;
  logic        tok_job;
  logic        cnt_ok;
  logic [16:0] radius;
  logic        accept;
  logic        done_after;

  assign up = to_upper(rx_byte);
  assign is_sep = (rx_byte == " ") || (rx_byte == 8'h09);
  assign is_etx = (rx_byte == ETX_BYTE);
  assign is_dig = (rx_byte >= "0") && (rx_byte <= "9");
  assign is_hex = (up >= "A") && (up <= "F");
  assign hd = is_dig ? 4'(rx_byte - "0") : 4'(up - "A" + 8'd10);
  assign dec_mul = {4'b0, decimal_value} * 21'd10 + {17'b0, hd};
  assign hex_mul = {hex_value, 4'b0} + {17'b0, hd};

  assign tok_end = in_frame && (is_sep || is_etx) && (token_length != 8'd0);
  assign tok_job = tok_end && (parse_phase == PH_DIST);
  assign cnt_ok = !token_flags[1] && !token_flags[2] && (hex_value >= 17'd1) &&
                  (hex_value <= {7'b0, COUNT_MAX});
  assign radius = token_flags[1] ? '0 :
                  token_flags[0] ? (token_flags[2] ? '0 : hex_value) : decimal_value;
  assign done_after = tok_job && ((point_counter + 10'd1) >= point_total);

  // An ETX that closes a distance token needs two jobs; pend_status holds the status job.
  always_comb begin
    job = '0;
    job_valid = 1'b0;
    if (pend_status) begin
      job.is_status = 1'b1;
      job.status_ok = (parse_phase == PH_DONE);
      job_valid = 1'b1;
    end else if (byte_valid && tok_job) begin
      job.emit = (point_counter < 10'(MAX_POINTS));
      job.index = point_counter;
      job.total = point_total;
      job.radius = radius;
      job_valid = 1'b1;
    end else if (byte_valid && in_frame && is_etx) begin
      job.is_status = 1'b1;
      job.status_ok = (parse_phase == PH_DONE);
      job_valid = 1'b1;
    end
  end

  assign byte_ready = !pend_status && (job_ready || !(in_frame && (tok_job || is_etx)));
  assign accept = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      parse_phase <= PH_SEEK;
      marker_match <= '0;
      token_length <= '0;
      hex_value <= '0;
      decimal_value <= '0;
      token_flags <= '0;
      point_total <= '0;
      point_counter <= '0;
      pend_status <= 1'b0;
    end else if (pend_status) begin
      if (job_ready) begin
        pend_status <= 1'b0;
        in_frame <= 1'b0;
        parse_phase <= PH_SEEK;
        point_total <= '0;
        point_counter <= '0;
      end
    end else if (accept) begin
      if (!in_frame) begin
        if (rx_byte == STX_BYTE) begin
          in_frame <= 1'b1;
          parse_phase <= PH_SEEK;
          point_total <= '0;
          point_counter <= '0;
          marker_match <= '0;
          token_length <= '0;
          hex_value <= '0;
          decimal_value <= '0;
          token_flags <= '0;
        end
      end else if (is_sep || is_etx) begin
        marker_match <= '0;
        token_length <= '0;
        hex_value <= '0;
        decimal_value <= '0;
        token_flags <= '0;
        if (tok_end) begin
          case (parse_phase)
            PH_SEEK: if (marker_match == 3'd5) parse_phase <= PH_COUNT;
            PH_COUNT: begin
              point_total <= cnt_ok ? hex_value[9:0] : COUNT_FALLBACK;
              point_counter <= '0;
              parse_phase <= PH_DIST;
            end
            PH_DIST: begin
              point_counter <= point_counter + 10'd1;
              if (done_after) parse_phase <= PH_DONE;
            end
            default: ;
          endcase
        end
        if (is_etx) begin
          if (tok_job) begin
            pend_status <= 1'b1;
          end else begin
            in_frame <= 1'b0;
            parse_phase <= PH_SEEK;
            point_total <= '0;
            point_counter <= '0;
          end
        end
      end else begin
        if (token_length != 8'd255) token_length <= token_length + 8'd1;
        if (marker_match < 3'd5 && up == marker_char(marker_match))
          marker_match <= marker_match + 3'd1;
        else
          marker_match <= MATCH_FAIL;
        if (is_dig) begin
          if (!token_flags[2])
            decimal_value <= (dec_mul > {4'b0, VALUE_CAP}) ? VALUE_CAP : dec_mul[16:0];
        end else if (is_hex) begin
          token_flags[0] <= 1'b1;
        end else if (rx_byte == ".") begin
          token_flags[2] <= 1'b1;
          if (token_flags[2]) token_flags[1] <= 1'b1;
        end else begin
          token_flags[1] <= 1'b1;
        end
        if (is_dig || is_hex)
          hex_value <= (hex_mul > {4'b0, VALUE_CAP}) ? VALUE_CAP : hex_mul[16:0];
      end
    end
  end

endmodule

// ----- rtl/lstx_engine.sv -----
// Point engine: angle division, sine polynomial and scaling, one job at a time.
`timescale 1ns / 1ps
module lstx_engine
  import lstx_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  output logic    job_ready,
  input  job_t    job,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  eng_state_t  state;
  eng_state_t  state_next;
  job_t        cur;
  logic [40:0] rem;
  logic [31:0] quo;
  logic [5:0]  bit_cnt;
  logic [9:0]  divisor;
  logic        neg;
  logic [30:0] t_sin;
  logic [30:0] t_cos;
  logic [30:0] u_sin;
  logic [30:0] u_cos;
  logic [30:0] h_sin;
  logic [30:0] h_cos;
  logic [2:0]  k;
  logic        half;
  logic [16:0] mag_x;
  logic [16:0] mag_y;

  logic [41:0] rem_sh;
  logic [41:0] rem_sub;
  logic [31:0] p_val;
  logic [31:0] t_val;
  logic [61:0] prod_a;
  logic [61:0] prod_b;
  logic [30:0] fin_s;
  logic [30:0] fin_c;
  logic [47:0] sc_x;
  logic [47:0] sc_y;

  assign divisor = cur.total - 10'd1;
  assign rem_sh = {rem, quo[31]};
  assign rem_sub = rem_sh - {32'b0, divisor};
  assign p_val = (cur.total > 10'd1) ? quo : 32'd0;
  assign t_val = (p_val > 32'h4000_0000) ? 32'h8000_0000 - p_val : p_val;

  // One shared multiplier product per cycle; the half flag picks the sin or cos lane.
  always_comb begin
    prod_a = '0;
    prod_b = '0;
    case (state)
      EN_SQ: begin
        prod_a = half ? {31'b0, t_cos} * {31'b0, t_cos}
                      : {31'b0, t_val[30:0]} * {31'b0, t_val[30:0]};
      end
      EN_POLY: begin
        prod_a = {31'b0, half ? u_cos : u_sin} * {31'b0, half ? h_cos : h_sin};
      end
      EN_FIN: begin
        prod_a = {31'b0, half ? t_cos : t_sin} * {31'b0, half ? h_cos : h_sin};
      end
      default: ;
    endcase
    prod_b = prod_a;
  end

  assign fin_s = (prod_b[61:30] > 32'h4000_0000) ? 31'h4000_0000 : prod_b[60:30];
  assign fin_c = fin_s;
  assign sc_x = {31'b0, cur.radius} * {17'b0, h_cos} + 48'h2000_0000;
  assign sc_y = {31'b0, cur.radius} * {17'b0, h_sin} + 48'h2000_0000;

  assign job_ready = (state == EN_IDLE);
  assign res_valid = (state == EN_OUT);

  always_comb begin
    state_next = state;
    case (state)
      EN_IDLE: if (job_valid) state_next = job.is_status ? EN_OUT : (job.emit ? EN_DIV : EN_IDLE);
      EN_DIV: if (bit_cnt == 6'd31) state_next = EN_SQ;
      EN_SQ: if (half) state_next = EN_POLY;
      EN_POLY: if (half && k == 3'd0) state_next = EN_FIN;
      EN_FIN: if (half) state_next = EN_SCALE;
      EN_SCALE: state_next = EN_OUT;
      EN_OUT: if (res_ready) state_next = EN_IDLE;
      default: state_next = EN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= EN_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      EN_IDLE: begin
        cur <= job;
        rem <= '0;
        quo <= {job.index, 22'b0};
        bit_cnt <= '0;
        half <= 1'b0;
        k <= 3'd5;
        h_sin <= 31'(sin_coef(3'd6));
        h_cos <= 31'(sin_coef(3'd6));
      end
      EN_DIV: begin
        // The index never exceeds the divisor, so the top quotient bit is one compare.
        // The low dividend bits, floor(d/2), are then shifted in over 31 steps.
        if (bit_cnt == 6'd0) begin
          if (cur.index >= divisor) begin
            rem <= {31'b0, cur.index - divisor};
            quo <= {22'b0, divisor[9:1], 1'b1};
          end else begin
            rem <= {31'b0, cur.index};
            quo <= {22'b0, divisor[9:1], 1'b0};
          end
        end
        bit_cnt <= bit_cnt + 6'd1;
        if (bit_cnt != 6'd0) begin
          if (!rem_sub[41]) begin
            rem <= rem_sub[40:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rem_sh[40:0];
            quo <= {quo[30:0], 1'b0};
          end
        end
      end
      EN_SQ: begin
        half <= !half;
        if (!half) begin
          t_sin <= t_val[30:0];
          t_cos <= 31'h4000_0000 - t_val[30:0];
          neg <= (p_val > 32'h4000_0000);
          u_sin <= prod_a[60:30];
        end
        if (half) u_cos <= prod_a[60:30];
      end
      EN_POLY: begin
        half <= !half;
        if (!half) h_sin <= sin_coef(k) - prod_a[60:30];
        else begin
          h_cos <= sin_coef(k) - prod_a[60:30];
          k <= k - 3'd1;
        end
      end
      EN_FIN: begin
        half <= !half;
        if (!half) h_sin <= fin_s;
        else h_cos <= fin_c;
      end
      EN_SCALE: begin
        mag_x <= sc_x[46:30];
        mag_y <= sc_y[46:30];
      end
      default: ;
    endcase
  end

  always_comb begin
    res = '0;
    if (cur.is_status) begin
      res.kind = cur.status_ok ? KIND_OK : KIND_ERROR;
      res.last = 1'b1;
    end else begin
      res.kind = KIND_POINT;
      res.point_index = cur.index;
      res.x_mm = neg ? 17'(-mag_x) : mag_x;
      res.y_mm = mag_y;
    end
  end

endmodule

// ----- rtl/lidar_scan_token_to_xy.sv -----
// Top level of the ASCII lidar scan to cartesian point converter.
//
// The s_axis channel takes the scan reply one byte per transaction.
// Bytes before STX are dropped; ETX closes the frame. The m_axis channel
// gives one transaction per emitted point (kind 0) and a closing status
// (kind 1 ok, kind 2 error) with tlast high.
// Bytes are taken at one per cycle while the job queue has room; an ETX
// that also closes a distance token holds s_axis_tready low until its
// status job is queued. A point job passes through the engine in order:
// a compare and 31 restoring steps for the angle division, then the
// squaring, polynomial and final multiplies on one shared multiplier,
// then a scaling step. The engine takes no new job while it computes or
// while its result waits on m_axis. The queue of four jobs lets the
// parser keep taking bytes while the engine works; a busy engine or a
// stalled m_axis receiver fills the queue and then stalls s_axis. Reset
// clears the parser, queue and engine state; the block leaves reset
// idle, outside a frame.
`timescale 1ns / 1ps
module lidar_scan_token_to_xy
  import lstx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // point_index, x_mm, y_mm, zero fill
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last
);

  logic    pj_valid;
  logic    pj_ready;
  job_t    pj;
  logic    qj_valid;
  logic    qj_ready;
  job_t    qj;
  result_t res;

  lstx_parser u_parser (
    .clk(clk), .rst(rst),
    .byte_valid(s_axis_tvalid), .byte_ready(s_axis_tready), .rx_byte(s_axis_tdata),
    .job_valid(pj_valid), .job_ready(pj_ready), .job(pj)
  );

  lstx_fifo u_fifo (
    .clk(clk), .rst(rst),
    .in_valid(pj_valid), .in_ready(pj_ready), .in_job(pj),
    .out_valid(qj_valid), .out_ready(qj_ready), .out_job(qj)
  );

  lstx_engine u_engine (
    .clk(clk), .rst(rst),
    .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = {4'b0, res.y_mm, res.x_mm, res.point_index};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// ----- rtl/lstx_checker.sv -----
// Port-level checker for the scan converter, bound to the top level.
`timescale 1ns / 1ps
module lstx_checker
  import lstx_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_POINT)))
    else $error("tlast disagrees with kind");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("unused kind code");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 48'd0)
    else $error("status carries point data");

endmodule

bind lidar_scan_token_to_xy lstx_checker u_checker (.*);

// ----- tb/lidar_scan_token_to_xy_tb.sv -----
// Self-checking testbench for the ASCII lidar scan to cartesian point converter.
`timescale 1ns / 1ps
module lidar_scan_token_to_xy_tb
  import lstx_pkg::*;
();

  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned PI_Q31 = 64'd2147483648;
  localparam logic [7:0] SPACE_CH = 8'h20;
  localparam logic [7:0] TAB_CH = 8'h09;
  localparam logic [2:0] SEEN_HEX = 3'b001;
  localparam logic [2:0] SEEN_BAD = 3'b010;
  localparam logic [2:0] SEEN_DOT = 3'b100;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_BYTES = 720;

  typedef struct {
    string      text;
    logic [1:0] status;
  } scan_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  lidar_scan_token_to_xy uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  // Shadow copy of the parser state.
  logic        sh_in_frame;
  phase_t      sh_phase;
  logic [2:0]  sh_match;
  logic [7:0]  sh_len;
  logic [16:0] sh_hex;
  logic [16:0] sh_dec;
  logic [2:0]  sh_flags;
  logic [9:0]  sh_total;
  logic [9:0]  sh_count;
  logic [1:0]  sh_last_status;

  result_t     pending_points[$];
  logic [7:0]  byte_q[$];
  int          send_idle;
  int          recv_idle;
  int          errors = 0;
  int          row_errors = 0;
  int          bytes_sent;
  int          frames_sent;
  int          points_seen = 0;
  int          status_seen = 0;
  int          cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned sine_q30(input longint unsigned t);
    longint unsigned u;
    longint unsigned h;
    logic [30:0]     coef[7];
    coef = '{31'd1686629713, 31'd693598669, 31'd85569306, 31'd5026995,
             31'd172272, 31'd3864, 31'd61};
    u = (t * t) >> 30;
    h = coef[6];
    for (int k = 5; k >= 0; k--) h = coef[k] - ((u * h) >> 30);
    h = (t * h) >> 30;
    return (h > ONE_Q30) ? ONE_Q30 : h;
  endfunction

  function automatic longint unsigned scale_mm(input longint unsigned r,
                                               input longint unsigned trig);
    return (r * trig + (ONE_Q30 >> 1)) >> 30;
  endfunction

  task automatic clear_token();
    sh_match = 3'd0;
    sh_len = 8'd0;
    sh_hex = 17'd0;
    sh_dec = 17'd0;
    sh_flags = 3'd0;
  endtask

  task automatic clear_frame();
    clear_token();
    sh_phase = PH_SEEK;
    sh_total = 10'd0;
    sh_count = 10'd0;
  endtask

  task automatic take_char(input logic [7:0] c);
    logic [7:0]  up;
    logic [4:0]  digit;
    logic [20:0] v;
    up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    digit = 5'd16;
    if (sh_len != 8'd255) sh_len++;
    if (sh_match < 3'd5 && up == marker_char(sh_match)) sh_match++;
    else sh_match = MATCH_FAIL;
    if (c >= "0" && c <= "9") begin
      digit = 5'(c - "0");
      if (!(sh_flags & SEEN_DOT)) begin
        v = 21'(sh_dec * 10 + digit);
        sh_dec = (v > VALUE_CAP) ? VALUE_CAP : v[16:0];
      end
    end else if (up >= "A" && up <= "F") begin
      digit = 5'(up - "A" + 10);
      sh_flags |= SEEN_HEX;
    end else if (c == ".") begin
      if (sh_flags & SEEN_DOT) sh_flags |= SEEN_BAD;
      sh_flags |= SEEN_DOT;
    end else begin
      sh_flags |= SEEN_BAD;
    end
    if (digit < 5'd16) begin
      v = 21'(sh_hex * 16 + digit);
      sh_hex = (v > VALUE_CAP) ? VALUE_CAP : v[16:0];
    end
  endtask

  task automatic close_token();
    longint unsigned r, d, p, t, xm, ym;
    logic            neg;
    result_t         pt;
    if (sh_len == 8'd0) return;
    case (sh_phase)
      PH_SEEK: begin
        if (sh_match == 3'd5) sh_phase = PH_COUNT;
      end
      PH_COUNT: begin
        sh_total = COUNT_FALLBACK;
        if (!(sh_flags & (SEEN_BAD | SEEN_DOT)) && sh_hex >= 1 && sh_hex <= COUNT_MAX)
          sh_total = sh_hex[9:0];
        sh_count = 10'd0;
        sh_phase = PH_DIST;
      end
      PH_DIST: begin
        if (sh_flags & SEEN_BAD) r = 0;
        else if (sh_flags & SEEN_HEX) r = (sh_flags & SEEN_DOT) ? 0 : sh_hex;
        else r = sh_dec;
        if (sh_count < MAX_POINTS) begin
          d = sh_total - 1;
          p = (sh_total > 1) ? (sh_count * PI_Q31 + (d >> 1)) / d : 0;
          neg = (p > ONE_Q30);
          t = neg ? PI_Q31 - p : p;
          if (t > ONE_Q30) t = ONE_Q30;
          xm = scale_mm(r, sine_q30(ONE_Q30 - t));
          ym = scale_mm(r, sine_q30(t));
          pt.kind = KIND_POINT;
          pt.point_index = sh_count;
          pt.x_mm = neg ? 17'(-xm) : 17'(xm);
          pt.y_mm = 17'(ym);
          pt.last = 1'b0;
          pending_points.push_back(pt);
        end
        sh_count++;
        if (sh_count >= sh_total) sh_phase = PH_DONE;
      end
      default: ;
    endcase
    clear_token();
  endtask

  task automatic predict_byte(input logic [7:0] c);
    result_t st;
    if (!sh_in_frame) begin
      if (c == STX_BYTE) begin
        sh_in_frame = 1'b1;
        clear_frame();
      end
    end else if (c == SPACE_CH || c == TAB_CH) begin
      close_token();
    end else if (c == ETX_BYTE) begin
      close_token();
      st = '0;
      st.kind = (sh_phase == PH_DONE) ? KIND_OK : KIND_ERROR;
      st.last = 1'b1;
      sh_last_status = st.kind;
      pending_points.push_back(st);
      sh_in_frame = 1'b0;
      clear_frame();
    end else begin
      take_char(c);
    end
  endtask

  task automatic send_queued();
    logic [7:0] b;
    while (byte_q.size() > 0) begin
      b = byte_q.pop_front();
      if ($urandom_range(99) < send_idle) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while ($urandom_range(99) < send_idle) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= b;
      do @(posedge clk); while (!s_axis_tready);
      predict_byte(b);
      bytes_sent++;
    end
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endtask

  function automatic string sep_text();
    case ($urandom_range(5))
      0: return "\t";
      1: return "  ";
      2: return " \t ";
      default: return " ";
    endcase
  endfunction

  function automatic string distance_text();
    string s;
    logic [7:0] c;
    case ($urandom_range(9))
      0, 1, 2: s = $sformatf("%0d", $urandom_range(70000));
      3: s = $sformatf("%0d", $urandom_range(999));
      4: s = $sformatf("%0d.%0d", $urandom_range(70000), $urandom_range(99));
      5: s = $sformatf("%0h", $urandom_range(32'hfffff, 10));
      6: begin
        s = $sformatf("%0h", $urandom_range(255));
        s = s.toupper();
      end
      7: s = $sformatf("%0d.%0d.%0d", $urandom_range(99), $urandom_range(9),
                       $urandom_range(9));
      default: begin
        s = "";
        for (int i = 0; i <= $urandom_range(3); i++) begin
          do c = $urandom_range(255);
          while (c == SPACE_CH || c == TAB_CH || c == ETX_BYTE);
          s = {s, string'(c)};
        end
      end
    endcase
    return s;
  endfunction

  task automatic queue_random_frame();
    int    n;
    int    ntok;
    string hdr;
    string cnt_s;
    logic [7:0] c;
    for (int i = 0; i < $urandom_range(3); i++) begin
      c = $urandom_range(255);
      byte_q.push_back(c);
    end
    byte_q.push_back(STX_BYTE);
    if ($urandom_range(3) == 0) queue_text({distance_text(), sep_text()});
    hdr = ($urandom_range(1)) ? "DIST1" : "dIsT1";
    if ($urandom_range(19) == 0) hdr = "DIST12";
    queue_text({hdr, sep_text()});
    n = $urandom_range(8, 1);
    case ($urandom_range(19))
      0: queue_text("0");
      1: queue_text("3e9");
      2: queue_text("1.0");
      3: queue_text("Zq");
      default: begin
        cnt_s = $sformatf("%0h", n);
        if ($urandom_range(1)) cnt_s = cnt_s.toupper();
        queue_text(cnt_s);
      end
    endcase
    ntok = n;
    if ($urandom_range(9) == 0) ntok = $urandom_range(n - 1);
    else if ($urandom_range(9) == 0) ntok = n + $urandom_range(2, 1);
    for (int i = 0; i < ntok; i++) queue_text({sep_text(), distance_text()});
    if ($urandom_range(1)) queue_text(sep_text());
    byte_q.push_back(ETX_BYTE);
  endtask

  scan_row_t rows[] = '{
    '{"\003x\002\003", KIND_ERROR},
    '{"\002DIST1 1 FFFF\003", KIND_OK},
    '{"\002dist1 3 0 65535 99999\003", KIND_OK},
    '{"\002 DIST1\t2\t1.9 1.2.3 \003", KIND_OK},
    '{"\002DIST1 2 aF a.f\003", KIND_OK},
    '{"\002DIST1 2 \0025 7 8\003", KIND_OK},
    '{"\002DIST1 ZZ 1\003", KIND_ERROR},
    '{"\002DIST2 1 5\003", KIND_ERROR},
    '{"\002DIST1 0 5\003", KIND_ERROR},
    '{"\002DIST1 3e9 5\003", KIND_ERROR},
    '{"\002DIST1 1 \003", KIND_ERROR}
  };

  always @(posedge clk) begin
    result_t want;
    logic [9:0]  got_idx;
    logic [16:0] got_x;
    logic [16:0] got_y;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_points.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_idx = m_axis_tdata[9:0];
        got_x = m_axis_tdata[26:10];
        got_y = m_axis_tdata[43:27];
        if (pending_points.size() == 0) begin
          $display("%0t unexpected transaction: kind %0d index %0d x %0d y %0d last %0b",
                   $time, m_axis_tuser, got_idx, $signed(got_x), $signed(got_y),
                   m_axis_tlast);
          errors++;
        end else begin
          want = pending_points.pop_front();
          if (m_axis_tuser !== want.kind || got_idx !== want.point_index ||
              got_x !== want.x_mm || got_y !== want.y_mm || m_axis_tlast !== want.last) begin
            $display("%0t mismatch: expected kind %0d index %0d x %0d y %0d last %0b",
                     $time, want.kind, want.point_index, $signed(want.x_mm),
                     $signed(want.y_mm), want.last);
            $display("%0t            actual kind %0d index %0d x %0d y %0d last %0b",
                     $time, m_axis_tuser, got_idx, $signed(got_x), $signed(got_y),
                     m_axis_tlast);
            errors++;
          end
          if (want.last) status_seen++;
          else points_seen++;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    int goal;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    bytes_sent = 0;
    frames_sent = 0;
    send_idle = 27;
    recv_idle = 57;
    sh_in_frame = 1'b0;
    sh_last_status = KIND_POINT;
    clear_frame();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      queue_text(rows[i].text);
      send_queued();
      frames_sent++;
      if (sh_last_status !== rows[i].status) begin
        $display("%0t row %0d: expected status %0d, actual %0d", $time, i,
                 rows[i].status, sh_last_status);
        row_errors++;
      end
    end

    // A long scan: more distances than the block emits points for.
    byte_q.push_back(STX_BYTE);
    queue_text("DIST1 16B");
    for (int i = 0; i < 363; i++) queue_text({" ", string'(8'("0" + i % 10))});
    byte_q.push_back(ETX_BYTE);
    send_queued();
    frames_sent++;

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 27 : (ph == 1) ? 57 : 0;
      recv_idle = (ph == 0) ? 57 : (ph == 1) ? 27 : 0;
      goal = bytes_sent + RANDOM_BYTES / 3;
      while (bytes_sent < goal) begin
        queue_random_frame();
        send_queued();
        frames_sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_points.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d bytes in %0d frames; checked %0d points and %0d frame statuses.",
             bytes_sent, frames_sent, points_seen, status_seen);
    if (errors + row_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors", errors + row_errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
